// ----- hw/rtl/amrle_pkg.sv -----
package amrle_pkg;

   // map geometry
   localparam int unsigned MAP_SIZE = 4096;
   localparam int unsigned FP_W     = $clog2(MAP_SIZE + 1);

   // result field widths
   localparam int unsigned ALPHA_W = 8;
   localparam int unsigned LEN_W   = 7;
   localparam int unsigned START_W = 12;

   // result queue geometry
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

   // run-length decode phase
   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_FILL = 2'd1,
      PH_COPY = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha_value;
      logic [LEN_W-1:0]   run_length;
      logic [START_W-1:0] start_index;
      logic               map_done;
      logic               decode_status;
   } result_type;

   // up to two results written into the queue per source byte
   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// ----- hw/rtl/amrle_core.sv -----
module amrle_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_src_byte,
   input  logic              req_src_last,
   input  logic              rle_enable,
   input  logic              full_byte_alpha,
   input  logic              room,
   output amrle_pkg::push_type push
);
   import amrle_pkg::*;

   localparam logic [FP_W-1:0] MAP_END = FP_W'(MAP_SIZE);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] src_byte_ff;
   logic       src_last_ff;

   // decode state
   logic [FP_W-1:0]  fill_position_ff, fill_position_in;
   phase_type        rle_phase_ff, rle_phase_in;
   logic [LEN_W-1:0] run_remaining_ff, run_remaining_in;
   logic             finished_ff, finished_in;

   logic advance;
   logic accept;

   logic [FP_W-1:0] left;
   logic [FP_W-1:0] fill_len;
   logic [FP_W-1:0] fp_step;
   logic [FP_W-1:0] fp_next;
   logic            zero_count;
   logic            full;
   logic            done;
   logic [1:0]      num;
   result_type      r0, r1;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   // clipped fill length
   assign left     = MAP_END - fill_position_ff;
   assign fill_len = (FP_W'(run_remaining_ff) > left) ? left : FP_W'(run_remaining_ff);

   // next phase
   always_comb begin
      rle_phase_in = rle_phase_ff;
      if (advance) begin
         if (finished_ff || (done && src_last_ff)) begin
            if (src_last_ff) rle_phase_in = PH_CTRL;
         end else if (rle_enable) begin
            unique case (rle_phase_ff)
               PH_FILL: rle_phase_in = PH_CTRL;
               PH_COPY: begin
                  if (run_remaining_ff == LEN_W'(1)) rle_phase_in = PH_CTRL;
               end
               default: begin
                  if (src_byte_ff[6:0] != 7'd0)
                     rle_phase_in = src_byte_ff[7] ? PH_FILL : PH_COPY;
               end
            endcase
         end
      end
   end

   // datapath: results and remaining state
   always_comb begin
      num        = 2'd0;
      r0         = '0;
      r1         = '0;
      zero_count = 1'b0;
      fp_step    = '0;
      run_remaining_in = run_remaining_ff;

      if (!finished_ff) begin
         if (rle_enable) begin
            unique case (rle_phase_ff)
               PH_FILL: begin
                  num              = 2'd1;
                  r0.alpha_value   = src_byte_ff;
                  r0.run_length    = fill_len[LEN_W-1:0];
                  r0.start_index   = START_W'(fill_position_ff);
                  fp_step          = fill_len;
                  run_remaining_in = '0;
               end
               PH_COPY: begin
                  num              = 2'd1;
                  r0.alpha_value   = src_byte_ff;
                  r0.run_length    = LEN_W'(1);
                  r0.start_index   = START_W'(fill_position_ff);
                  fp_step          = FP_W'(1);
                  run_remaining_in = run_remaining_ff - LEN_W'(1);
               end
               default: begin
                  if (src_byte_ff[6:0] == 7'd0) begin
                     zero_count = 1'b1;
                  end else begin
                     run_remaining_in = src_byte_ff[6:0];
                  end
               end
            endcase
         end else if (full_byte_alpha) begin
            num            = 2'd1;
            r0.alpha_value = src_byte_ff;
            r0.run_length  = LEN_W'(1);
            r0.start_index = START_W'(fill_position_ff);
            fp_step        = FP_W'(1);
         end else begin
            // nibble times 17 is the nibble repeated
            num            = 2'd1;
            r0.alpha_value = {src_byte_ff[3:0], src_byte_ff[3:0]};
            r0.run_length  = LEN_W'(1);
            r0.start_index = START_W'(fill_position_ff);
            fp_step        = FP_W'(1);
            if (fill_position_ff + FP_W'(1) < MAP_END) begin
               num            = 2'd2;
               r1.alpha_value = {src_byte_ff[7:4], src_byte_ff[7:4]};
               r1.run_length  = LEN_W'(1);
               r1.start_index = START_W'(fill_position_ff + FP_W'(1));
               fp_step        = FP_W'(2);
            end
         end
      end

      fp_next = fill_position_ff + fp_step;
      full    = fp_next >= MAP_END;
      done    = !finished_ff && (full || zero_count || src_last_ff);

      // end of map marking, status-only result when nothing was filled
      if (done) begin
         if (num == 2'd0) begin
            num            = 2'd1;
            r0             = '0;
            r0.start_index = START_W'(fp_next);
         end
         if (num == 2'd2) begin
            r1.map_done      = 1'b1;
            r1.decode_status = !full;
         end else begin
            r0.map_done      = 1'b1;
            r0.decode_status = !full;
         end
      end

      // state updates
      fill_position_in = fill_position_ff;
      finished_in      = finished_ff;
      if (advance) begin
         if (src_last_ff && (finished_ff || done)) begin
            fill_position_in = '0;
            run_remaining_in = '0;
            finished_in      = 1'b0;
         end else if (!finished_ff) begin
            fill_position_in = fp_next;
            finished_in      = done;
         end
      end else begin
         run_remaining_in = run_remaining_ff;
      end

      push.num = advance ? num : 2'd0;
      push.r0  = r0;
      push.r1  = r1;
   end

   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         fill_position_ff <= '0;
         rle_phase_ff     <= PH_CTRL;
         run_remaining_ff <= '0;
         finished_ff      <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         fill_position_ff <= fill_position_in;
         rle_phase_ff     <= rle_phase_in;
         run_remaining_ff <= run_remaining_in;
         finished_ff      <= finished_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         src_byte_ff <= req_src_byte;
         src_last_ff <= req_src_last;
      end
   end

endmodule

// ----- hw/rtl/amrle_result_fifo.sv -----
module amrle_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  amrle_pkg::push_type   push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output amrle_pkg::result_type head
);
   import amrle_pkg::*;

   result_type       entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = entry_ff[rd_ptr_ff];
   // two free slots cover the largest push
   assign room      = count_ff <= CNT_W'(FIFO_DEPTH - 2);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) entry_ff[wr_ptr_ff] <= push.r0;
      if (push.num == 2'd2) entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.r1;
   end

endmodule

// ----- hw/rtl/alpha_map_rle_nibble_decoder.sv -----
// path: a source byte is held in the input register, and its results in the result queue, before they are offered
// throughput: 1 source byte per cycle when each byte yields at most one result and
//   the result channel is not stalled; in nibble mode each byte yields two results, so
//   bytes are held back by the one-per-cycle result port
// reset: synchronous, active high; clears the decode state, the result queue
//   and both mode registers
module alpha_map_rle_nibble_decoder (
   input  logic        clock,
   input  logic        reset,
   // source byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_src_byte,
   input  logic        req_src_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_alpha_value,
   output logic [6:0]  rsp_run_length,
   output logic [11:0] rsp_start_index,
   output logic        rsp_map_done,
   output logic        rsp_decode_status,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import amrle_pkg::*;

   localparam logic REG_RLE_ENABLE      = 1'b0;
   localparam logic REG_FULL_BYTE_ALPHA = 1'b1;

   logic       rle_enable_ff, rle_enable_in;
   logic       full_byte_alpha_ff, full_byte_alpha_in;
   logic       csr_write;
   logic       room;
   push_type   push;
   result_type head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_comb begin
      rle_enable_in      = rle_enable_ff;
      full_byte_alpha_in = full_byte_alpha_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_RLE_ENABLE:      rle_enable_in      = csr_pwdata[0];
            REG_FULL_BYTE_ALPHA: full_byte_alpha_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_enable_ff      <= 1'b0;
         full_byte_alpha_ff <= 1'b0;
      end else begin
         rle_enable_ff      <= rle_enable_in;
         full_byte_alpha_ff <= full_byte_alpha_in;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[2])
         REG_RLE_ENABLE:      csr_prdata = {31'd0, rle_enable_ff};
         REG_FULL_BYTE_ALPHA: csr_prdata = {31'd0, full_byte_alpha_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // byte decode
   amrle_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_byte    (req_src_byte),
      .req_src_last    (req_src_last),
      .rle_enable      (rle_enable_ff),
      .full_byte_alpha (full_byte_alpha_ff),
      .room            (room),
      .push            (push)
   );

   // result queue
   amrle_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_alpha_value   = head.alpha_value;
   assign rsp_run_length    = head.run_length;
   assign rsp_start_index   = head.start_index;
   assign rsp_map_done      = head.map_done;
   assign rsp_decode_status = head.decode_status;

endmodule

// ----- hw/rtl/amrle_checker.sv -----
module amrle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_alpha_value,
   input logic [6:0]  rsp_run_length,
   input logic [11:0] rsp_start_index,
   input logic        rsp_map_done,
   input logic        rsp_decode_status
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alpha_value)
         && $stable(rsp_run_length) && $stable(rsp_start_index)
         && $stable(rsp_map_done) && $stable(rsp_decode_status))
      else $error("result changed while stalled");

   // error status only on the end-of-map result
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_status |-> rsp_map_done)
      else $error("status without map done");

   // an empty run is a status-only result
   a_empty_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_length == 7'd0 |-> rsp_map_done && rsp_alpha_value == 8'd0)
      else $error("empty run that does not end the map");

   // queue empties on reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind alpha_map_rle_nibble_decoder amrle_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import amrle_pkg::*;

   // register byte addresses
   localparam logic [2:0] ADDR_RLE_ENABLE      = 3'd0;
   localparam logic [2:0] ADDR_FULL_BYTE_ALPHA = 3'd4;

   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // idling profiles
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_SENDER = 1;
   localparam int IDLE_STALL  = 2;
   localparam int IDLE_BOTH   = 3;

   typedef struct {
      logic [7:0] src_byte;
      logic       src_last;
   } src_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_src_byte = 8'd0;
   logic        req_src_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_alpha_value;
   logic [6:0]  rsp_run_length;
   logic [11:0] rsp_start_index;
   logic        rsp_map_done;
   logic        rsp_decode_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alpha_map_rle_nibble_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_src_byte      (req_src_byte),
      .req_src_last      (req_src_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_alpha_value   (rsp_alpha_value),
      .rsp_run_length    (rsp_run_length),
      .rsp_start_index   (rsp_start_index),
      .rsp_map_done      (rsp_map_done),
      .rsp_decode_status (rsp_decode_status),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock, 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // source bytes waiting to be sent, runs still due from the decoder
   src_item_type src_bytes_pending[$];
   result_type   alpha_runs_due[$];
   src_item_type next_src;
   int           queued_count = 0;
   int           accepted_count = 0;
   int           decoded_items = 0;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;

   // mirror of the decoder: mode registers and map state
   logic             mode_rle = 1'b0;
   logic             mode_full_byte = 1'b0;
   logic [FP_W-1:0]  fill_pos = '0;
   phase_type        rle_ph = PH_CTRL;
   logic [LEN_W-1:0] run_left = '0;
   logic             map_closed = 1'b0;

   function automatic result_type make_run(input logic [7:0] value, input logic [6:0] len,
                                           input logic [FP_W-1:0] pos);
      result_type r;
      r.alpha_value   = value;
      r.run_length    = len;
      r.start_index   = pos[START_W-1:0];
      r.map_done      = 1'b0;
      r.decode_status = 1'b0;
      return r;
   endfunction

   task automatic clear_map();
      fill_pos   = '0;
      rle_ph     = PH_CTRL;
      run_left   = '0;
      map_closed = 1'b0;
   endtask

   // decode one source byte and queue the runs it produces
   task automatic decode_alpha_byte(input logic [7:0] b, input logic last);
      result_type       runs [2];
      int               n;
      logic [FP_W-1:0]  room;
      logic [LEN_W-1:0] len;
      logic             zero_cnt;
      logic             full;
      n = 0;
      zero_cnt = 1'b0;
      // map already done: ignore until the last byte
      if (map_closed) begin
         if (last) clear_map();
         return;
      end
      decoded_items++;
      if (mode_rle) begin
         case (rle_ph)
            PH_FILL: begin
               room = FP_W'(MAP_SIZE) - fill_pos;
               len = (FP_W'(run_left) > room) ? room[LEN_W-1:0] : run_left;
               runs[n] = make_run(b, len, fill_pos);
               n++;
               fill_pos = fill_pos + FP_W'(len);
               rle_ph = PH_CTRL;
               run_left = '0;
            end
            PH_COPY: begin
               runs[n] = make_run(b, 7'd1, fill_pos);
               n++;
               fill_pos = fill_pos + FP_W'(1);
               run_left = run_left - LEN_W'(1);
               if (run_left == '0) rle_ph = PH_CTRL;
            end
            default: begin
               if (b[6:0] == 7'd0) begin
                  zero_cnt = 1'b1;
               end else begin
                  rle_ph = b[7] ? PH_FILL : PH_COPY;
                  run_left = b[6:0];
               end
            end
         endcase
      end else if (mode_full_byte) begin
         runs[n] = make_run(b, 7'd1, fill_pos);
         n++;
         fill_pos = fill_pos + FP_W'(1);
      end else begin
         // nibble unpack, low nibble first, scaled to full range
         runs[n] = make_run(8'(b[3:0] * 17), 7'd1, fill_pos);
         n++;
         fill_pos = fill_pos + FP_W'(1);
         if (fill_pos < FP_W'(MAP_SIZE)) begin
            runs[n] = make_run(8'(b[7:4] * 17), 7'd1, fill_pos);
            n++;
            fill_pos = fill_pos + FP_W'(1);
         end
      end
      // end of map: full, zero count or last byte
      full = (fill_pos >= FP_W'(MAP_SIZE));
      if (full || zero_cnt || last) begin
         if (n == 0) begin
            runs[n] = make_run(8'd0, 7'd0, fill_pos);
            n++;
         end
         runs[n-1].map_done = 1'b1;
         runs[n-1].decode_status = !full;
         if (last) clear_map();
         else map_closed = 1'b1;
      end
      for (int i = 0; i < n; i++) alpha_runs_due.push_back(runs[i]);
   endtask

   // source driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_alpha_byte(req_src_byte, req_src_last);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (src_bytes_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_src = src_bytes_pending.pop_front();
               req_valid <= 1'b1;
               req_src_byte <= next_src.src_byte;
               req_src_last <= next_src.src_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alpha_runs_due.size() == 0) begin
               $display("%0t unexpected transaction: alpha %0h len %0d start %0d done %0b status %0b",
                        $time, rsp_alpha_value, rsp_run_length, rsp_start_index,
                        rsp_map_done, rsp_decode_status);
               mismatches++;
            end else begin
               want = alpha_runs_due.pop_front();
               check_field("alpha_value", 32'(want.alpha_value), 32'(rsp_alpha_value));
               check_field("run_length", 32'(want.run_length), 32'(rsp_run_length));
               check_field("start_index", 32'(want.start_index), 32'(rsp_start_index));
               check_field("map_done", 32'(want.map_done), 32'(rsp_map_done));
               check_field("decode_status", 32'(want.decode_status),
                           32'(rsp_decode_status));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_src(input logic [7:0] b, input logic last);
      src_item_type item;
      item.src_byte = b;
      item.src_last = last;
      src_bytes_pending.push_back(item);
      queued_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || alpha_runs_due.size() != 0)
         @(posedge clock);
      // a control byte may still be in flight without a result
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic bit_value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= {31'($urandom), bit_value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // only called with the decoder idle
   task automatic set_modes(input logic rle, input logic full_byte);
      csr_write(ADDR_RLE_ENABLE, rle);
      mode_rle = rle;
      csr_write(ADDR_FULL_BYTE_ALPHA, full_byte);
      mode_full_byte = full_byte;
   endtask

   task automatic set_idle(input int profile);
      idle_pct  = (profile == IDLE_SENDER) ? 46 : (profile == IDLE_BOTH) ? 6 : 0;
      stall_pct = (profile == IDLE_STALL) ? 46 : (profile == IDLE_BOTH) ? 6 : 0;
   endtask

   // fill runs up to gap positions short of the end; gap 0 fills the map
   task automatic gen_rle_full(input int gap);
      int   pos;
      int   cnt;
      int   left;
      logic closing;
      pos = 0;
      while (int'(MAP_SIZE) - pos > 127 + gap) begin
         cnt = $urandom_range(64, 127);
         push_src(8'h80 | 8'(cnt), 1'b0);
         push_src(8'($urandom), 1'b0);
         pos += cnt;
      end
      left = int'(MAP_SIZE) - gap - pos;
      if (gap > 0) begin
         // leave the map open near its end
         push_src(8'h80 | 8'(left), 1'b0);
         push_src(8'($urandom), 1'b0);
         return;
      end
      closing = 1'($urandom_range(0, 1));
      cnt = $urandom_range(left, 127);
      if ($urandom_range(0, 1)) begin
         // clipped fill run
         push_src(8'h80 | 8'(cnt), 1'b0);
         push_src(8'($urandom), closing);
      end else begin
         // copy run crossing the end, extra literals ignored
         push_src(8'(cnt), 1'b0);
         for (int i = 0; i < cnt; i++) push_src(8'($urandom), closing && i == cnt - 1);
      end
      if (!closing) begin
         repeat ($urandom_range(0, 2)) push_src(8'($urandom), 1'b0);
         push_src(8'($urandom), 1'b1);
      end
   endtask

   // short run-length map with random runs and a random ending
   task automatic gen_rle_random();
      logic [7:0] seq[$];
      int         cnt;
      int         keep;
      repeat ($urandom_range(1, 5)) begin
         cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
         if ($urandom_range(0, 1)) begin
            seq.push_back(8'h80 | 8'(cnt));
            seq.push_back(8'($urandom));
         end else begin
            seq.push_back(8'(cnt));
            repeat (cnt) seq.push_back(8'($urandom));
         end
      end
      case ($urandom_range(0, 5))
         0: begin
            // zero count ends the map, trailing bytes ignored
            seq.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
         end
         1: seq.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
         2: begin
            // source cut short anywhere
            keep = $urandom_range(1, seq.size());
            while (seq.size() > keep) void'(seq.pop_back());
         end
         3: foreach (seq[i]) seq[i] = 8'($urandom);
         default: ;
      endcase
      foreach (seq[i]) push_src(seq[i], i == seq.size() - 1);
   endtask

   task automatic gen_plain_map();
      int n;
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) push_src(8'($urandom), i == n - 1);
   endtask

   // stimulus
   initial begin
      int phase_idx;
      int item_goal;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // nibble mode straight out of reset
      push_src(8'h00, 1'b0);
      push_src(8'hFF, 1'b0);
      push_src(8'h5A, 1'b1);
      wait_drained();

      // full-byte mode
      set_modes(1'b0, 1'b1);
      push_src(8'h00, 1'b0);
      push_src(8'hFF, 1'b1);
      wait_drained();

      // run-length mode
      set_modes(1'b1, 1'b0);
      push_src(8'hFF, 1'b0);      // longest fill
      push_src(8'hAB, 1'b0);
      push_src(8'h01, 1'b0);      // one literal
      push_src(8'h80, 1'b0);
      push_src(8'h81, 1'b0);
      push_src(8'h00, 1'b0);
      push_src(8'h80, 1'b0);      // zero count with the fill bit
      push_src(8'h55, 1'b0);      // ignored after the end
      push_src(8'hFF, 1'b1);      // ignored, clears for the next map
      push_src(8'h83, 1'b0);
      push_src(8'hC3, 1'b1);      // source short after a fill
      push_src(8'h05, 1'b1);      // last on a control byte
      push_src(8'h00, 1'b1);      // zero count with last
      push_src(8'h03, 1'b0);
      push_src(8'h11, 1'b0);
      push_src(8'h22, 1'b1);      // cut inside a copy run
      wait_drained();

      // random phases over all mode settings and idling profiles
      phase_idx = 0;
      item_goal = decoded_items + RANDOM_ITEMS;
      while (decoded_items < item_goal) begin
         set_idle((phase_idx + phase_idx / 4) % 4);
         case (phase_idx % 4)
            0: set_modes(1'b1, 1'b0);
            1: set_modes(1'b0, 1'b0);
            2: set_modes(1'b1, 1'b1);
            default: set_modes(1'b0, 1'b1);
         endcase
         if (mode_rle) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 4) == 0) gen_rle_full(0);
               else gen_rle_random();
            end
            // map left open near its end for the next mode
            if ($urandom_range(0, 2) == 0) gen_rle_full($urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(1, 3)) gen_plain_map();
         end
         wait_drained();
         phase_idx++;
      end

      set_idle(IDLE_NONE);
      wait_drained();
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/amrle_pkg.sv
hw/rtl/amrle_core.sv
hw/rtl/amrle_result_fifo.sv
hw/rtl/alpha_map_rle_nibble_decoder.sv
hw/rtl/amrle_checker.sv
tb/sv/tb.sv
